[sv/square_root_decimal_places_assert.svh]
// assertion macros for the truncated decimal square root block
// included by the top level; no other dependencies
`ifndef SQUARE_ROOT_DECIMAL_PLACES_ASSERT_SVH
`define SQUARE_ROOT_DECIMAL_PLACES_ASSERT_SVH

`ifndef SYNTHESIS
// plain condition checked at every clock edge outside reset
`define SRDP_ASSERT(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("srdp assertion failed");
// condition in this cycle implies consequence in the next
`define SRDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("srdp assertion failed");
`else
`define SRDP_ASSERT(lbl, clk, rstn, cond)
`define SRDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[sv/srdp_pkg.sv]
// shared constants and types for the truncated decimal square root block
// no dependencies
package srdp_pkg;

    localparam int RAD_W    = 31;
    localparam int PLACES_W = 3;
    localparam int ROOT_W   = 29;

    localparam int S_DATA_W = ((RAD_W + PLACES_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((ROOT_W + 7) / 8) * 8;

    // status of the radicand scaler toward the cell chain
    typedef struct packed {
        logic busy;
        logic done;
    } scale_status_t;

endpackage

[sv/square_root_decimal_places.sv]
// top level of the truncated decimal square root: floor(sqrt(n) * 10^p)
// depends on srdp_pkg, srdp_scale, srdp_cell, square_root_decimal_places_assert.svh
//
//  channel | dir | fields (tdata from bit 0 up)
//  s_axis  | in  | radicand[30:0], decimal_places[33:31], zero pad to 40
//  m_axis  | out | root_scaled[28:0], zero pad to 32
//
// one item at a time: an accepted beat is scaled, then walks the cell chain; p is the
// clamped place count and RW the number of cells (29 at MAX_PLACES = 4)
// the scaler multiplies by 100 once for each of the p places, then the item walks the cell
// chain one cell a cycle; a new beat is taken the cycle the result is registered
// a stalled m side freezes the chain; reset clears only valid and busy flags
`include "square_root_decimal_places_assert.svh"

module square_root_decimal_places
    import srdp_pkg::*;
#(
    parameter int MAX_PLACES = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // radicand, decimal_places, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // root_scaled, zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    function automatic longint unsigned pow100(input int e);
        longint unsigned acc;
        acc = 1;
        for (int i = 0; i < e; i++) begin
            acc = acc * 100;
        end
        return acc;
    endfunction

    localparam int SCALE_W = $clog2(pow100(MAX_PLACES) + 1);
    localparam int VAL_W   = RAD_W + SCALE_W;
    localparam int RW      = (VAL_W + 1) / 2;

    logic                busy_reg, busy_next;
    logic                out_valid_reg;
    logic [ROOT_W-1:0]   out_data_reg;
    logic                s_fire;
    logic                load;
    logic                adv;
    scale_status_t       scale_st;
    logic [VAL_W-1:0]    scaled;

    logic                vld_w  [RW+1];
    logic [RW+1:0]       rem_w  [RW+1];
    logic [RW-1:0]       root_w [RW+1];
    logic [2*RW-1:0]     rad_w  [RW+1];
    logic [RW-1:0]       cell_vld;
    logic [ROOT_W+RW-1:0] root_ext;

    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;

    srdp_scale #(
        .VAL_W      (VAL_W),
        .MAX_PLACES (MAX_PLACES)
    ) u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_fire),
        .radicand (s_tdata[RAD_W-1:0]),
        .places   (s_tdata[RAD_W+PLACES_W-1:RAD_W]),
        .status   (scale_st),
        .scaled   (scaled)
    );

    assign vld_w[0]  = scale_st.done;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign rad_w[0]  = (2*RW)'(scaled);

    for (genvar i = 0; i < RW; i++) begin : g_cell
        srdp_cell #(
            .RW (RW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (vld_w[i]),
            .in_rem    (rem_w[i]),
            .in_root   (root_w[i]),
            .in_rad    (rad_w[i]),
            .out_valid (vld_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_root  (root_w[i+1]),
            .out_rad   (rad_w[i+1])
        );
        assign cell_vld[i] = vld_w[i+1];
    end

    // last cell hands over when the output register is free or being drained
    assign load = vld_w[RW] && (!out_valid_reg || m_tready);
    assign adv  = !(vld_w[RW] && !load);

    assign root_ext = {{ROOT_W{1'b0}}, root_w[RW]};

    always_comb begin
        busy_next = busy_reg;
        if (s_fire) begin
            busy_next = 1'b1;
        end else if (load) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (load) begin
            out_data_reg <= root_ext[ROOT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_data_reg);

    // only one item is ever in flight between scaler and chain
    `SRDP_ASSERT(a_one_in_flight, aclk, aresetn, $onehot0({scale_st.busy, cell_vld}))
    // an idle block holds nothing in the scaler or the chain
    `SRDP_ASSERT(a_idle_empty, aclk, aresetn, busy_reg || (!scale_st.busy && cell_vld == '0))
    // the scaler never finishes into a frozen chain
    `SRDP_ASSERT(a_done_advances, aclk, aresetn, !scale_st.done || adv)
    // a handed over result shows up on the m side next cycle
    `SRDP_ASSERT_NEXT(a_load_shows, aclk, aresetn, load, m_tvalid && !busy_reg)

endmodule

[sv/srdp_scale.sv]
// radicand scaler: multiplies the radicand by 100 once per decimal place
// depends on srdp_pkg
module srdp_scale
    import srdp_pkg::*;
#(
    parameter int VAL_W      = 58,
    parameter int MAX_PLACES = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [RAD_W-1:0]    radicand,
    input  logic [PLACES_W-1:0] places,
    output scale_status_t       status,
    output logic [VAL_W-1:0]    scaled
);

    localparam logic [PLACES_W-1:0] MAX_P = PLACES_W'(MAX_PLACES);

    logic                busy_reg, busy_next;
    logic [PLACES_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [PLACES_W-1:0] places_clamped;

    assign places_clamped = (places > MAX_P) ? MAX_P : places;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = places_clamped;
            val_next  = VAL_W'(radicand);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                // times 100 as 64 + 32 + 4
                val_next = (val_reg << 6) + (val_reg << 5) + (val_reg << 2);
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= cnt_next;
        val_reg <= val_next;
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && (cnt_reg == '0);
    assign scaled      = val_reg;

endmodule

[sv/srdp_cell.sv]
// one restoring square root cell: settles one root bit from two radicand bits
// no dependencies
module srdp_cell #(
    parameter int RW = 29
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [RW+1:0]   in_rem,
    input  logic [RW-1:0]   in_root,
    input  logic [2*RW-1:0] in_rad,
    output logic            out_valid,
    output logic [RW+1:0]   out_rem,
    output logic [RW-1:0]   out_root,
    output logic [2*RW-1:0] out_rad
);

    logic            valid_reg;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [2*RW-1:0] rad_reg, rad_next;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            fits;

    // remainder stays below 2^RW, so the top bits drop out in the shift
    assign rem_sh = {in_rem[RW-1:0], in_rad[2*RW-1:2*RW-2]};
    assign trial  = {in_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_comb begin
        rem_next  = fits ? (rem_sh - trial) : rem_sh;
        root_next = {in_root[RW-2:0], fits};
        rad_next  = {in_rad[2*RW-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;

endmodule
